@@ rtl/core/kst_pkg.sv @@
`timescale 1ns / 1ps
package kst_pkg;

  localparam int SLOTS       = 16;
  localparam int KEY_BITS    = 16;
  localparam int HANDLE_BITS = 16;
  localparam int IDX_BITS    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_BITS    = $clog2(SLOTS + 1);
  localparam int ACT_BITS    = 5;
  localparam int STAT_BITS   = 2;
  localparam int REQ_BITS    = 2;
  localparam int QDEPTH      = 2;
  localparam int QPTR_BITS   = 1;
  localparam int QCNT_BITS   = 2;

  localparam logic [ACT_BITS-1:0] ACTIVE_RESET = ACT_BITS'(SLOTS);

  localparam logic [STAT_BITS-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_BITS-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_BITS-1:0] STAT_MISS = 2'd2;

  typedef enum logic [REQ_BITS-1:0] {
    OP_LOAD   = 2'd0,
    OP_UNLOAD = 2'd1,
    OP_QUERY  = 2'd2,
    OP_SCAN   = 2'd3
  } op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    op_t                    op;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
  } cmd_t;

  typedef struct packed {
    logic                   valid;
    cmd_t                   cmd;
  } cmd_link_t;

  typedef struct packed {
    logic [STAT_BITS-1:0]   status;
    logic                   found;
    logic [IDX_BITS-1:0]    slot_index;
    logic [KEY_BITS-1:0]    out_key;
    logic [HANDLE_BITS-1:0] out_handle;
    logic                   item_valid;
    logic [CNT_BITS-1:0]    loaded_total;
    logic                   table_full;
    logic                   last;
  } rsp_t;

  typedef struct packed {
    logic                hit;
    logic [IDX_BITS-1:0] idx;
  } pick_t;

  // lowest set bit
  function automatic pick_t pick_low(logic [SLOTS-1:0] m);
    pick_t p;
    p = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (m[i]) begin
        p.hit = 1'b1;
        p.idx = IDX_BITS'(i);
      end
    end
    return p;
  endfunction

  // highest set bit
  function automatic pick_t pick_high(logic [SLOTS-1:0] m);
    pick_t p;
    p = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (m[i]) begin
        p.hit = 1'b1;
        p.idx = IDX_BITS'(i);
      end
    end
    return p;
  endfunction

endpackage

@@ rtl/core/kst_if.sv @@
`timescale 1ns / 1ps
interface kst_req_if;
  logic                            valid;
  logic                            ready;
  logic [kst_pkg::REQ_BITS-1:0]    req_type;
  logic [kst_pkg::KEY_BITS-1:0]    key;
  logic [kst_pkg::HANDLE_BITS-1:0] handle;

  modport source (output valid, req_type, key, handle, input ready);
  modport sink   (input valid, req_type, key, handle, output ready);
endinterface

interface kst_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [kst_pkg::STAT_BITS-1:0]   status;
  logic                            found;
  logic [kst_pkg::IDX_BITS-1:0]    slot_index;
  logic [kst_pkg::KEY_BITS-1:0]    out_key;
  logic [kst_pkg::HANDLE_BITS-1:0] out_handle;
  logic                            item_valid;
  logic [kst_pkg::CNT_BITS-1:0]    loaded_total;
  logic                            table_full;
  logic                            last;

  modport source (output valid, status, found, slot_index, out_key, out_handle,
                  item_valid, loaded_total, table_full, last, input ready);
  modport sink   (input valid, status, found, slot_index, out_key, out_handle,
                  item_valid, loaded_total, table_full, last, output ready);
endinterface

@@ rtl/core/kst_front.sv @@
`timescale 1ns / 1ps
module kst_front (
  input  logic               clk,
  input  logic               rst,
  kst_req_if.sink            req,
  output kst_pkg::cmd_link_t link,
  input  logic               pop
);

  kst_pkg::cmd_t                  queue [kst_pkg::QDEPTH];
  logic [kst_pkg::QPTR_BITS-1:0]  wr_ptr;
  logic [kst_pkg::QPTR_BITS-1:0]  rd_ptr;
  logic [kst_pkg::QCNT_BITS-1:0]  fill;
  kst_pkg::cmd_t                  decoded;
  logic                           push;
  logic                           take;

  always_comb begin
    decoded.key    = req.key;
    decoded.handle = req.handle;
    unique case (req.req_type)
      kst_pkg::OP_LOAD:   decoded.op = kst_pkg::OP_LOAD;
      kst_pkg::OP_UNLOAD: decoded.op = kst_pkg::OP_UNLOAD;
      kst_pkg::OP_QUERY:  decoded.op = kst_pkg::OP_QUERY;
      default:            decoded.op = kst_pkg::OP_SCAN;
    endcase
  end

  assign req.ready  = (fill != kst_pkg::QCNT_BITS'(kst_pkg::QDEPTH));
  assign push       = req.valid && req.ready;
  assign link.valid = (fill != '0);
  assign link.cmd   = queue[rd_ptr];
  assign take       = pop && link.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + kst_pkg::QPTR_BITS'(1);
      end
      if (take) begin
        rd_ptr <= rd_ptr + kst_pkg::QPTR_BITS'(1);
      end
      if (push && !take) begin
        fill <= fill + kst_pkg::QCNT_BITS'(1);
      end else if (take && !push) begin
        fill <= fill - kst_pkg::QCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= decoded;
    end
  end

endmodule

@@ rtl/core/kst_back.sv @@
`timescale 1ns / 1ps
module kst_back (
  input  logic                         clk,
  input  logic                         rst,
  input  kst_pkg::cmd_link_t           link,
  output logic                         pop,
  input  logic                         cfg_we,
  input  logic [kst_pkg::ACT_BITS-1:0] cfg_wdata,
  kst_rsp_if.source                    rsp
);

  logic [kst_pkg::ACT_BITS-1:0]    active;
  logic [kst_pkg::SLOTS-1:0]       valid;
  logic [kst_pkg::SLOTS-1:0]       valid_next;
  logic [kst_pkg::KEY_BITS-1:0]    slot_key    [kst_pkg::SLOTS];
  logic [kst_pkg::HANDLE_BITS-1:0] slot_handle [kst_pkg::SLOTS];
  logic [kst_pkg::CNT_BITS-1:0]    count;
  logic [kst_pkg::CNT_BITS-1:0]    count_next;
  logic [kst_pkg::CNT_BITS-1:0]    eff;
  logic [kst_pkg::SLOTS-1:0]       act_mask;
  logic [kst_pkg::SLOTS-1:0]       match_mask;
  kst_pkg::pick_t                  free_pick;
  kst_pkg::pick_t                  match_pick;
  kst_pkg::pick_t                  high_pick;
  kst_pkg::state_t                 state;
  kst_pkg::state_t                 state_next;
  logic [kst_pkg::IDX_BITS-1:0]    idx;
  logic [kst_pkg::IDX_BITS-1:0]    idx_next;
  logic [kst_pkg::IDX_BITS-1:0]    last_idx;
  logic [kst_pkg::IDX_BITS-1:0]    last_idx_next;
  logic                            wr_en;
  logic                            emit;
  logic                            can_write;
  logic                            out_valid;
  kst_pkg::rsp_t                   res;
  kst_pkg::rsp_t                   out_reg;
  logic                            scan_done;

  assign eff = (active > kst_pkg::ACT_BITS'(kst_pkg::SLOTS)) ?
               kst_pkg::CNT_BITS'(kst_pkg::SLOTS) : kst_pkg::CNT_BITS'(active);

  always_comb begin
    for (int i = 0; i < kst_pkg::SLOTS; i++) begin
      act_mask[i]   = (kst_pkg::CNT_BITS'(i) < eff);
      match_mask[i] = valid[i] && act_mask[i] && (slot_key[i] == link.cmd.key);
    end
  end

  assign free_pick  = kst_pkg::pick_low(~valid & act_mask);
  assign match_pick = kst_pkg::pick_low(match_mask);
  assign high_pick  = kst_pkg::pick_high(valid & act_mask);
  assign can_write  = !out_valid || rsp.ready;
  assign scan_done  = valid[idx] && can_write && (idx == last_idx);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      kst_pkg::S_IDLE: begin
        if (link.valid && can_write && link.cmd.op == kst_pkg::OP_SCAN && high_pick.hit) begin
          state_next = kst_pkg::S_SCAN;
        end
      end
      kst_pkg::S_SCAN: begin
        if (scan_done) begin
          state_next = kst_pkg::S_IDLE;
        end
      end
      default: state_next = kst_pkg::S_IDLE;
    endcase
  end

  // outputs and table updates
  always_comb begin
    pop           = 1'b0;
    emit          = 1'b0;
    wr_en         = 1'b0;
    valid_next    = valid;
    count_next    = count;
    idx_next      = idx;
    last_idx_next = last_idx;
    res           = '0;
    unique case (state)
      kst_pkg::S_IDLE: begin
        if (link.valid && can_write) begin
          pop      = 1'b1;
          emit     = 1'b1;
          res.last = 1'b1;
          unique case (link.cmd.op)
            kst_pkg::OP_LOAD: begin
              if (free_pick.hit) begin
                valid_next[free_pick.idx] = 1'b1;
                wr_en          = 1'b1;
                count_next     = count + kst_pkg::CNT_BITS'(1);
                res.slot_index = free_pick.idx;
              end else begin
                res.status = kst_pkg::STAT_FULL;
              end
            end
            kst_pkg::OP_UNLOAD: begin
              if (match_pick.hit) begin
                valid_next[match_pick.idx] = 1'b0;
                if (count != '0) begin
                  count_next = count - kst_pkg::CNT_BITS'(1);
                end
                res.slot_index = match_pick.idx;
              end else begin
                res.status = kst_pkg::STAT_MISS;
              end
            end
            kst_pkg::OP_QUERY: begin
              res.found = match_pick.hit;
            end
            default: begin
              if (high_pick.hit) begin
                emit          = 1'b0;
                idx_next      = '0;
                last_idx_next = high_pick.idx;
              end
            end
          endcase
        end
      end
      kst_pkg::S_SCAN: begin
        if (valid[idx]) begin
          if (can_write) begin
            emit           = 1'b1;
            res.slot_index = idx;
            res.out_key    = slot_key[idx];
            res.out_handle = slot_handle[idx];
            res.item_valid = 1'b1;
            res.last       = (idx == last_idx);
            if (idx != last_idx) begin
              idx_next = idx + kst_pkg::IDX_BITS'(1);
            end
          end
        end else begin
          idx_next = idx + kst_pkg::IDX_BITS'(1);
        end
      end
      default: ;
    endcase
    res.loaded_total = count_next;
    res.table_full   = (count_next >= eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kst_pkg::S_IDLE;
      active    <= kst_pkg::ACTIVE_RESET;
      valid     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
      last_idx  <= '0;
    end else if (cfg_we) begin
      active <= cfg_wdata;
      valid  <= '0;
      count  <= '0;
    end else begin
      state    <= state_next;
      valid    <= valid_next;
      count    <= count_next;
      idx      <= idx_next;
      last_idx <= last_idx_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_key[free_pick.idx]    <= link.cmd.key;
      slot_handle[free_pick.idx] <= link.cmd.handle;
    end
    if (emit) begin
      out_reg <= res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_reg.status;
  assign rsp.found        = out_reg.found;
  assign rsp.slot_index   = out_reg.slot_index;
  assign rsp.out_key      = out_reg.out_key;
  assign rsp.out_handle   = out_reg.out_handle;
  assign rsp.item_valid   = out_reg.item_valid;
  assign rsp.loaded_total = out_reg.loaded_total;
  assign rsp.table_full   = out_reg.table_full;
  assign rsp.last         = out_reg.last;

endmodule

@@ rtl/core/keyed_slot_table.sv @@
`timescale 1ns / 1ps
// load, unload, query: request held in the front queue, then result registered
// one request per cycle for those while rsp.ready is high and no scan is busy
// scan: a start step, then one beat per loaded slot up to the highest loaded slot
// rst clears all valid marks and the loaded count, active slots returns to 16
// a write of active_slots also clears the table
module keyed_slot_table (
  input  logic                         clk,
  input  logic                         rst,
  kst_req_if.sink                      req,
  kst_rsp_if.source                    rsp,
  input  logic                         cfg_we,
  input  logic [kst_pkg::ACT_BITS-1:0] cfg_wdata
);

  kst_pkg::cmd_link_t link;
  logic               pop;

  kst_front u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .link (link),
    .pop  (pop)
  );

  kst_back u_back (
    .clk       (clk),
    .rst       (rst),
    .link      (link),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rsp       (rsp)
  );

endmodule
